>>> rtl/core/lfu_pkg.sv
package lfu_pkg;

  localparam int ENTRIES_DEFAULT = 16;
  localparam int CAP_W           = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam int COUNT_W         = 16;
  localparam int STAMP_W         = 40;
  localparam int WORD_W          = 32;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  localparam logic FUNC_GET = 1'b0;
  localparam logic FUNC_PUT = 1'b1;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef struct packed {
    logic                     func;
    logic signed [WORD_W-1:0] key;
    logic signed [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic                     found;
    logic signed [WORD_W-1:0] read_value;
    logic                     evicted;
    logic signed [WORD_W-1:0] evicted_key;
  } res_t;

  // running result of the scan, passed cell to cell
  typedef struct packed {
    logic                hit;
    logic [WORD_W-1:0]   hit_data;
    logic                vic;
    logic [COUNT_W-1:0]  vic_count;
    logic [STAMP_W-1:0]  vic_stamp;
    logic [WORD_W-1:0]   vic_key;
    logic                free;
  } scan_t;

  // write-back command broadcast to all cells
  typedef struct packed {
    logic                we;
    logic                insert;
    logic                set_data;
    logic [WORD_W-1:0]   key;
    logic [WORD_W-1:0]   data;
    logic [STAMP_W-1:0]  stamp;
  } wr_t;

endpackage

>>> rtl/core/lfu_cache_replacement_top.sv
// channel   ports                   handshake
// -------   ---------------------   ---------------------------------------
// command   start, busy, cmd        word taken when start && !busy
// result    done, result            word valid for the one cycle done is high
// config    cfg_we, cfg_wdata       capacity written when cfg_we is high
//
// A command passes through the launch register, then walks the chain of
// ENTRIES slot cells, each of which registers the scan word, and then the
// result register. Write-back happens at the
// end of the scan, so a new command can start in the result cycle.
// rst (synchronous) clears all slots, the stamp counter and sets capacity
// to 16. The receiver cannot stall; done is a one-cycle strobe.
module lfu_cache_replacement_top #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  lfu_pkg::cmd_t              cmd,
  output logic                       done,
  output lfu_pkg::res_t              result,
  input  logic                       cfg_we,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;

  lfu_pkg::state_t state, state_next;

  logic [lfu_pkg::CAP_W-1:0]    capacity;
  logic [lfu_pkg::STAMP_W-1:0]  stamp_counter;
  lfu_pkg::cmd_t                q;
  logic                         launch;
  logic                         accept;
  logic                         finish;

  logic            vld      [ENTRIES+1];
  lfu_pkg::scan_t  rec      [ENTRIES+1];
  logic [IDX_W-1:0] hit_idx [ENTRIES+1];
  logic [IDX_W-1:0] vic_idx [ENTRIES+1];
  logic [IDX_W-1:0] free_idx[ENTRIES+1];
  logic [OCC_W-1:0] occ     [ENTRIES+1];

  lfu_pkg::wr_t      wr;
  logic [IDX_W-1:0]  wr_idx;
  lfu_pkg::res_t     res_next;

  lfu_pkg::scan_t    last;
  logic [CMP_W-1:0]  cap_eff;
  logic              use_vic;

  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      lfu_pkg::ST_IDLE: if (start) state_next = lfu_pkg::ST_SCAN;
      lfu_pkg::ST_SCAN: if (vld[ENTRIES]) state_next = lfu_pkg::ST_IDLE;
      default:          state_next = lfu_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = 1'b0;
    finish = 1'b0;
    case (state)
      lfu_pkg::ST_IDLE: busy = 1'b0;
      lfu_pkg::ST_SCAN: begin
        busy   = 1'b1;
        finish = vld[ENTRIES];
      end
      default: busy = 1'b0;
    endcase
  end

  assign vld[0]      = launch;
  assign rec[0]      = '0;
  assign hit_idx[0]  = '0;
  assign vic_idx[0]  = '0;
  assign free_idx[0] = '0;
  assign occ[0]      = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .ENTRIES(ENTRIES),
      .IDX    (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .qkey       (q.key),
      .up_valid   (vld[i]),
      .up_rec     (rec[i]),
      .up_hit_idx (hit_idx[i]),
      .up_vic_idx (vic_idx[i]),
      .up_free_idx(free_idx[i]),
      .up_occ     (occ[i]),
      .dn_valid   (vld[i+1]),
      .dn_rec     (rec[i+1]),
      .dn_hit_idx (hit_idx[i+1]),
      .dn_vic_idx (vic_idx[i+1]),
      .dn_free_idx(free_idx[i+1]),
      .dn_occ     (occ[i+1]),
      .wr         (wr),
      .wr_idx     (wr_idx)
    );
  end

  assign last    = rec[ENTRIES];
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES)
                                                         : CMP_W'(capacity);
  assign use_vic = (CMP_W'(occ[ENTRIES]) >= cap_eff && last.vic) || !last.free;

  always_comb begin
    wr          = '0;
    wr.key      = q.key;
    wr.data     = q.value;
    wr.stamp    = stamp_counter;
    wr_idx      = hit_idx[ENTRIES];
    res_next    = '0;
    res_next.found = last.hit;
    if (finish) begin
      if (q.func == lfu_pkg::FUNC_GET) begin
        if (last.hit) begin
          res_next.read_value = last.hit_data;
          wr.we = 1'b1;
        end
      end else if (cap_eff != '0) begin
        wr.we = 1'b1;
        if (last.hit) begin
          wr.set_data = 1'b1;
        end else begin
          wr.insert = 1'b1;
          if (use_vic) begin
            wr_idx               = vic_idx[ENTRIES];
            res_next.evicted     = 1'b1;
            res_next.evicted_key = last.vic_key;
          end else begin
            wr_idx = free_idx[ENTRIES];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= lfu_pkg::ST_IDLE;
      capacity      <= lfu_pkg::CAP_RESET;
      stamp_counter <= '0;
      launch        <= 1'b0;
      done          <= 1'b0;
    end else begin
      state  <= state_next;
      launch <= accept;
      done   <= finish;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (wr.we) begin
        stamp_counter <= stamp_counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q <= cmd;
    end
    if (finish) begin
      result <= res_next;
    end
  end

endmodule

>>> rtl/core/lfu_cell.sv
module lfu_cell #(
  parameter int ENTRIES = lfu_pkg::ENTRIES_DEFAULT,
  parameter int IDX     = 0,
  localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
  localparam int OCC_W  = $clog2(ENTRIES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [lfu_pkg::WORD_W-1:0]  qkey,
  input  logic                        up_valid,
  input  lfu_pkg::scan_t              up_rec,
  input  logic [IDX_W-1:0]            up_hit_idx,
  input  logic [IDX_W-1:0]            up_vic_idx,
  input  logic [IDX_W-1:0]            up_free_idx,
  input  logic [OCC_W-1:0]            up_occ,
  output logic                        dn_valid,
  output lfu_pkg::scan_t              dn_rec,
  output logic [IDX_W-1:0]            dn_hit_idx,
  output logic [IDX_W-1:0]            dn_vic_idx,
  output logic [IDX_W-1:0]            dn_free_idx,
  output logic [OCC_W-1:0]            dn_occ,
  input  lfu_pkg::wr_t                wr,
  input  logic [IDX_W-1:0]            wr_idx
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                         valid;
  logic [lfu_pkg::WORD_W-1:0]   key;
  logic [lfu_pkg::WORD_W-1:0]   data;
  logic [lfu_pkg::COUNT_W-1:0]  count;
  logic [lfu_pkg::STAMP_W-1:0]  stamp;

  lfu_pkg::scan_t       rec_next;
  logic [IDX_W-1:0]     hit_idx_next;
  logic [IDX_W-1:0]     vic_idx_next;
  logic [IDX_W-1:0]     free_idx_next;
  logic [OCC_W-1:0]     occ_next;
  logic                 sel;

  always_comb begin
    rec_next      = up_rec;
    hit_idx_next  = up_hit_idx;
    vic_idx_next  = up_vic_idx;
    free_idx_next = up_free_idx;
    occ_next      = up_occ;
    if (valid) begin
      occ_next = up_occ + 1'b1;
      if (!up_rec.hit && key == qkey) begin
        rec_next.hit      = 1'b1;
        rec_next.hit_data = data;
        hit_idx_next      = MY_IDX;
      end
      if (!up_rec.vic || count < up_rec.vic_count ||
          (count == up_rec.vic_count && stamp < up_rec.vic_stamp)) begin
        rec_next.vic       = 1'b1;
        rec_next.vic_count = count;
        rec_next.vic_stamp = stamp;
        rec_next.vic_key   = key;
        vic_idx_next       = MY_IDX;
      end
    end else if (!up_rec.free) begin
      rec_next.free = 1'b1;
      free_idx_next = MY_IDX;
    end
  end

  assign sel = wr.we && (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      dn_valid <= up_valid;
      if (sel && wr.insert) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid) begin
      dn_rec      <= rec_next;
      dn_hit_idx  <= hit_idx_next;
      dn_vic_idx  <= vic_idx_next;
      dn_free_idx <= free_idx_next;
      dn_occ      <= occ_next;
    end
    if (sel) begin
      stamp <= wr.stamp;
      if (wr.insert) begin
        key   <= wr.key;
        data  <= wr.data;
        count <= lfu_pkg::COUNT_W'(1);
      end else begin
        if (wr.set_data) begin
          data <= wr.data;
        end
        if (count != lfu_pkg::COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
    end
  end

endmodule
